@@ hdl/afc54_pkg.sv @@
// Shared types, constants and symbol mapping for the 54-symbol affine cipher.
// Used by afc54_ctrl, afc54_dp and affine_cipher_54_symbol.
package afc54_pkg;

  localparam int unsigned SymCount = 54;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_ALPHA = 2'd1;
  localparam logic [1:0] ST_NOT_INV   = 2'd2;

  // Configuration register indexes
  localparam logic CFG_KEY_MULT = 1'b0;
  localparam logic CFG_KEY_ADD  = 1'b1;

  // floor(p / 54) = (p * DivRecip) >> DivShift, exact for p < 8192
  localparam int unsigned DivShift = 19;
  localparam logic [13:0] DivRecip = 14'd9710;

  typedef struct packed {
    logic load_item;
    logic inv_start;
    logic inv_step;
    logic do_mul;
    logic do_div;
    logic out_load_pass;
    logic out_load_res;
  } cmd_t;

  typedef struct packed {
    logic in_alpha;
    logic invertible;
    logic inv_ready;
    logic inv_found;
    logic out_free;
  } sts_t;

  // Byte to symbol; valid only where in_alphabet holds
  function automatic logic [5:0] to_sym(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= 8'd65 && c <= 8'd90) begin
      t = c - 8'd65;
    end else if (c >= 8'd97 && c <= 8'd122) begin
      t = c - 8'd71;
    end else if (c == 8'd165) begin
      t = 8'd52;
    end else begin
      t = 8'd53;
    end
    return t[5:0];
  endfunction

  function automatic logic in_alphabet(input logic [7:0] c);
    return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122) ||
           (c == 8'd165) || (c == 8'd164);
  endfunction

  function automatic logic [7:0] to_byte(input logic [5:0] s);
    logic [7:0] b;
    b = 8'd164;
    if (s <= 6'd25) begin
      b = {2'b00, s} + 8'd65;
    end else if (s <= 6'd51) begin
      b = {2'b00, s} + 8'd71;
    end else if (s == 6'd52) begin
      b = 8'd165;
    end
    return b;
  endfunction

  // Reduce a 6-bit register value into 0..53
  function automatic logic [5:0] red54(input logic [5:0] v);
    return (v >= 6'd54) ? v - 6'd54 : v;
  endfunction

  // Coprime to 54 = 2 * 3^3: odd and not a multiple of 3
  function automatic logic coprime54(input logic [5:0] m);
    logic [3:0] s;
    // m mod 3 == (even-position bits + 2 * odd-position bits) mod 3
    s = {3'b000, m[0]} + {3'b000, m[2]} + {3'b000, m[4]} +
        {2'b00, m[1], 1'b0} + {2'b00, m[3], 1'b0} + {2'b00, m[5], 1'b0};
    return m[0] && !(s == 4'd0 || s == 4'd3 || s == 4'd6 || s == 4'd9);
  endfunction

endpackage

@@ hdl/affine_cipher_54_symbol.sv @@
// Top level of the 54-symbol affine cipher: stream in, stream out, key port.
// Depends on afc54_pkg, afc54_ctrl and afc54_dp.
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata = char_in, s_tuser = mode
// m_*       out  m_tvalid/m_tready  m_tdata = char_out, m_tuser = status
// cfg_*     in   cfg_we             cfg_index selects key_mult / key_add
//
// An enciphered or deciphered character passes from transfer to result through
// check, multiply, reciprocal divide by 54, remainder and map-back.
// A pass-through character (outside the alphabet, or key_mult not coprime
// to 54) goes from check straight to the output register. The first cipher
// character after a key write adds the inverse search, one candidate per cycle.
// rst is synchronous and restores key_mult = 1, key_add = 0, no inverse.
// A result held in the output register while m_tready is low does not block
// the next input transfer; the block stalls only when its next result needs
// that register.
module affine_cipher_54_symbol import afc54_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_in
  input  logic       s_tuser,   // [0] mode: 0 encrypt, 1 decrypt
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] char_out
  output logic [1:0] m_tuser,   // [1:0] status
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [5:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  // Sequencing: one item in flight, output register decoupled from input
  afc54_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Keys, inverse cache, arithmetic and output register
  afc54_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

@@ hdl/afc54_dp.sv @@
// Datapath: key registers, inverse search, multiply and modulo-54 reduction,
// output register. Depends on afc54_pkg; driven by afc54_ctrl commands.
module afc54_dp import afc54_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [5:0] cfg_wdata,
  input  logic [7:0] s_tdata,
  input  logic       s_tuser,
  output logic [7:0] m_tdata,
  output logic [1:0] m_tuser,
  output logic       m_tvalid,
  input  logic       m_tready,
  input  cmd_t       cmd,
  output sts_t       sts
);

  logic [5:0]  key_mult;
  logic [5:0]  key_add;
  logic [5:0]  inv_key;
  logic        inv_ready;
  logic [5:0]  cand;
  logic [5:0]  acc;
  logic [7:0]  char_q;
  logic        mode_q;
  logic [12:0] prod;
  logic [7:0]  quot;

  logic [5:0]  m_red;
  logic [5:0]  a_red;
  logic [5:0]  sym;
  logic [6:0]  acc_sum;
  logic [6:0]  diff;
  logic [12:0] prod_next;
  logic [26:0] quot_wide;
  logic [13:0] rem_wide;
  logic        out_free;

  assign m_red = red54(key_mult);
  assign a_red = red54(key_add);
  assign sym   = to_sym(char_q);
  assign out_free = !m_tvalid || m_tready;

  assign acc_sum = {1'b0, acc} + {1'b0, m_red};
  assign diff    = {1'b0, sym} + 7'd54 - {1'b0, a_red};

  always_comb begin
    if (mode_q) begin
      prod_next = 13'({7'd0, inv_key} * {6'd0, diff});
    end else begin
      prod_next = 13'({7'd0, m_red} * {7'd0, sym}) + {7'd0, a_red};
    end
  end

  assign quot_wide = {14'd0, prod} * {13'd0, DivRecip};
  assign rem_wide  = {1'b0, prod} - 14'({6'd0, quot} * 14'd54);

  assign sts.in_alpha   = in_alphabet(char_q);
  assign sts.invertible = coprime54(m_red);
  assign sts.inv_ready  = inv_ready;
  assign sts.inv_found  = (acc == 6'd1);
  assign sts.out_free   = out_free;

  // Keys and cached inverse
  always_ff @(posedge clk) begin
    if (rst) begin
      key_mult  <= 6'd1;
      key_add   <= 6'd0;
      inv_key   <= 6'd0;
      inv_ready <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_KEY_MULT) begin
        key_mult <= cfg_wdata;
      end else begin
        key_add <= cfg_wdata;
      end
      inv_ready <= 1'b0;
    end else if (cmd.inv_step && acc == 6'd1) begin
      inv_key   <= cand;
      inv_ready <= 1'b1;
    end
  end

  // Search for k with m*k == 1 mod 54, one candidate a cycle
  always_ff @(posedge clk) begin
    if (cmd.inv_start) begin
      cand <= 6'd1;
      acc  <= m_red;
    end else if (cmd.inv_step) begin
      cand <= cand + 6'd1;
      acc  <= (acc_sum >= 7'd54) ? 6'(acc_sum - 7'd54) : acc_sum[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      char_q <= s_tdata;
      mode_q <= s_tuser;
    end
    if (cmd.do_mul) begin
      prod <= prod_next;
    end
    if (cmd.do_div) begin
      quot <= quot_wide[DivShift +: 8];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load_pass || cmd.out_load_res) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load_pass) begin
      m_tdata <= char_q;
      m_tuser <= sts.in_alpha ? ST_NOT_INV : ST_NOT_ALPHA;
    end else if (cmd.out_load_res) begin
      m_tdata <= to_byte(rem_wide[5:0]);
      m_tuser <= ST_OK;
    end
  end

endmodule

@@ hdl/afc54_ctrl.sv @@
// Controller state machine: sequences accept, inverse search, multiply,
// divide and output load. Depends on afc54_pkg.
module afc54_ctrl import afc54_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_INV   = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_RED   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_item = 1'b1;
          state_next    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.in_alpha || !sts.invertible) begin
          if (sts.out_free) begin
            cmd.out_load_pass = 1'b1;
            state_next        = S_IDLE;
          end
        end else if (!sts.inv_ready) begin
          cmd.inv_start = 1'b1;
          state_next    = S_INV;
        end else begin
          state_next = S_MUL;
        end
      end
      S_INV: begin
        cmd.inv_step = 1'b1;
        if (sts.inv_found) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.do_mul = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.do_div = 1'b1;
        state_next = S_RED;
      end
      S_RED: begin
        if (sts.out_free) begin
          cmd.out_load_res = 1'b1;
          state_next       = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ sim/affine_cipher_54_symbol_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for affine_cipher_54_symbol: streams characters under many keys
// and checks each result against a cipher predictor kept in a small scoreboard class.
// Depends on afc54_pkg (status codes, register indexes) and the affine_cipher_54_symbol RTL.
module affine_cipher_54_symbol_test;
  import afc54_pkg::*;

  // Direction carried on s_tuser
  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  localparam int unsigned ALPHABET_SIZE = 54;
  localparam int unsigned ITEMS_PER_KEY = 110;
  localparam int unsigned KEY_SETTINGS  = 18;
  // The last few key settings run with both sides at full rate
  localparam int unsigned CALM_SETTINGS = 2;
  // Drain wait: covers the inverse search plus the cipher pipeline, with margin
  localparam int unsigned DRAIN_CYCLES  = 70;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef struct packed {
    logic [7:0] char_out;
    logic [1:0] status;
  } cipher_result_t;

  // Cipher predictor plus the queue of results still owed by the block.
  class cipher_scoreboard;
    logic [5:0]     mult_key;
    logic [5:0]     add_key;
    logic [5:0]     inv_key;
    bit             inv_valid;
    cipher_result_t expected_q[$];
    int unsigned    mismatches;

    function new();
      mult_key   = 6'd1;
      add_key    = 6'd0;
      inv_key    = 6'd0;
      inv_valid  = 1'b0;
      mismatches = 0;
    endfunction

    // Any key write invalidates the cached inverse
    function void write_key(logic idx, logic [5:0] value);
      if (idx == CFG_KEY_MULT) begin
        mult_key = value;
      end else begin
        add_key = value;
      end
      inv_valid = 1'b0;
    endfunction

    function bit symbol_of(logic [7:0] ch, output int unsigned sym);
      sym = 0;
      if (ch >= "A" && ch <= "Z") begin
        sym = ch - "A";
      end else if (ch >= "a" && ch <= "z") begin
        sym = ch - "a" + 26;
      end else if (ch == 8'd165) begin
        sym = 52;
      end else if (ch == 8'd164) begin
        sym = 53;
      end else begin
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function logic [7:0] byte_of(int unsigned sym);
      if (sym < 26) begin
        return 8'("A" + sym);
      end else if (sym < 52) begin
        return 8'("a" + sym - 26);
      end else if (sym == 52) begin
        return 8'd165;
      end
      return 8'd164;
    endfunction

    // Brute-force search; the caller guarantees m is a unit modulo 54
    function logic [5:0] inverse_of(int unsigned m);
      for (int unsigned k = 1; k < ALPHABET_SIZE; k++) begin
        if ((m * k) % ALPHABET_SIZE == 1) begin
          return 6'(k);
        end
      end
      return 6'd0;
    endfunction

    // Predict the result of one accepted character
    function void note_transfer(logic mode, logic [7:0] ch);
      int unsigned    m;
      int unsigned    a;
      int unsigned    x;
      int unsigned    y;
      cipher_result_t r;
      m = mult_key % ALPHABET_SIZE;
      a = add_key % ALPHABET_SIZE;
      r.char_out = ch;
      if (!symbol_of(ch, x)) begin
        r.status = ST_NOT_ALPHA;
      end else if (m % 2 == 0 || m % 3 == 0) begin
        r.status = ST_NOT_INV;
      end else begin
        if (!inv_valid) begin
          inv_key   = inverse_of(m);
          inv_valid = 1'b1;
        end
        if (mode == MODE_ENCRYPT) begin
          y = (m * x + a) % ALPHABET_SIZE;
        end else begin
          y = (inv_key * (x + ALPHABET_SIZE - a)) % ALPHABET_SIZE;
        end
        r.char_out = byte_of(y);
        r.status   = ST_OK;
      end
      expected_q.push_back(r);
    endfunction

    function void report(string what, cipher_result_t want, cipher_result_t got);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%0t: %s: expected char %0d status %0d, got char %0d status %0d",
                 $realtime, what, want.char_out, want.status, got.char_out, got.status);
      end
    endfunction

    // Compare one output transfer with the oldest prediction
    function void check_result(logic [7:0] ch, logic [1:0] st);
      cipher_result_t got;
      cipher_result_t want;
      got.char_out = ch;
      got.status   = st;
      if (expected_q.size() == 0) begin
        report("result with nothing pending", '0, got);
        return;
      end
      want = expected_q.pop_front();
      if (got.char_out !== want.char_out || got.status !== want.status) begin
        report("mismatch", want, got);
      end
    endfunction
  endclass

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       s_tvalid  = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata   = 8'd0;
  logic       s_tuser   = MODE_ENCRYPT;
  logic       m_tvalid;
  logic       m_tready  = 1'b0;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       cfg_we    = 1'b0;
  logic       cfg_index = CFG_KEY_MULT;
  logic [5:0] cfg_wdata = 6'd0;

  cipher_scoreboard sb;
  bit               idling = 1'b1;  // random gaps on both sides while set
  int unsigned      ready_hold = 0;  // remaining cycles of a receiver stall

  affine_cipher_54_symbol uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Receiver: check every output transfer, then pick m_tready for the next cycle.
  // Values read here are the ones from before the edge, so no race with the RTL.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_result(m_tdata, m_tuser);
    end
    if (ready_hold != 0) begin
      ready_hold = ready_hold - 1;
      m_tready <= 1'b0;
    end else if (idling && !rst && $urandom_range(0, 5) == 0) begin
      // start a receiver stall burst
      ready_hold = $urandom_range(0, 4);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Offer one character and hold it until the transfer happens
  task automatic send_char(input logic mode, input logic [7:0] ch);
    if (idling && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tuser  <= mode;
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
    sb.note_transfer(mode, ch);
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Write both keys back to back; only call while the block is idle
  task automatic write_keys(input logic [5:0] mult, input logic [5:0] add);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_KEY_MULT;
    cfg_wdata <= mult;
    @(posedge clk);
    sb.write_key(CFG_KEY_MULT, mult);
    cfg_index <= CFG_KEY_ADD;
    cfg_wdata <= add;
    @(posedge clk);
    sb.write_key(CFG_KEY_ADD, add);
    cfg_we <= 1'b0;
  endtask

  // Mostly alphabet characters, the rest any byte at all
  function automatic logic [7:0] random_char();
    if ($urandom_range(0, 4) == 0) begin
      return 8'($urandom_range(0, 255));
    end
    return sb.byte_of($urandom_range(0, ALPHABET_SIZE - 1));
  endfunction

  initial begin
    logic [7:0]  alpha_bounds [6];
    logic [7:0]  outside_chars [8];
    logic [5:0]  mult;
    logic [5:0]  add;
    int unsigned m54;
    sb = new();
    alpha_bounds  = '{8'd65, 8'd90, 8'd97, 8'd122, 8'd165, 8'd164};
    outside_chars = '{8'd0, 8'd255, 8'd64, 8'd91, 8'd96, 8'd123, 8'd163, 8'd166};

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset keys: identity cipher, inverse derived from key_mult = 1
    send_char(MODE_ENCRYPT, "M");
    send_char(MODE_DECRYPT, 8'd165);
    wait_idle();

    // Directed: alphabet boundaries in both modes, bytes just outside each range
    write_keys(6'd5, 6'd7);
    foreach (alpha_bounds[i]) begin
      send_char(MODE_ENCRYPT, alpha_bounds[i]);
      send_char(MODE_DECRYPT, alpha_bounds[i]);
    end
    foreach (outside_chars[i]) begin
      send_char(i % 2 == 0 ? MODE_ENCRYPT : MODE_DECRYPT, outside_chars[i]);
    end
    wait_idle();

    // Key sweep. Each setting ends with the sender paused until the block drains,
    // so every key write lands on an idle block.
    for (int unsigned setting = 0; setting < KEY_SETTINGS; setting++) begin
      case (setting)
        0: begin
          mult = 6'd53;  // largest unit, largest shift
          add  = 6'd53;
        end
        1: begin
          mult = 6'd0;  // zero multiplier, flagged
          add  = 6'd0;
        end
        2: begin
          mult = 6'd54;  // reduces to zero, flagged; add reduces to 9
          add  = 6'd63;
        end
        3: begin
          mult = 6'd63;  // reduces to 9, not a unit
          add  = 6'd12;
        end
        4: begin
          mult = 6'd1;
          add  = 6'd0;
        end
        5: begin
          mult = 6'd25;
          add  = 6'd60;
        end
        6: begin
          mult = 6'd2;  // even, not a unit
          add  = 6'd3;
        end
        7: begin
          mult = 6'd55;  // reduces to 1
          add  = 6'd9;
        end
        default: begin
          // Mostly units so the cipher path dominates
          mult = 6'($urandom_range(0, 63));
          m54  = mult % ALPHABET_SIZE;
          while ($urandom_range(0, 4) != 0 && (m54 % 2 == 0 || m54 % 3 == 0)) begin
            mult = 6'($urandom_range(0, 63));
            m54  = mult % ALPHABET_SIZE;
          end
          add = 6'($urandom_range(0, 63));
        end
      endcase
      idling = (setting < KEY_SETTINGS - CALM_SETTINGS);
      write_keys(mult, add);
      for (int unsigned n = 0; n < ITEMS_PER_KEY; n++) begin
        send_char($urandom_range(0, 1) == 0 ? MODE_ENCRYPT : MODE_DECRYPT, random_char());
      end
      wait_idle();
    end

    // Allow any stray result to show up before judging
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("affine_cipher_54_symbol_test: clean");
    end else begin
      $display("affine_cipher_54_symbol_test: errors");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("affine_cipher_54_symbol_test: errors");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/afc54_pkg.sv
hdl/afc54_dp.sv
hdl/afc54_ctrl.sv
hdl/affine_cipher_54_symbol.sv
sim/affine_cipher_54_symbol_test.sv
